### hw/rtl/imh_pkg.sv
package imh_pkg;

	localparam int CAPACITY = 1024;
	localparam int HANDLES  = 1024;
	localparam int KEY_BITS = 32;

	localparam int POS_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int HND_W = $clog2(HANDLES);
	localparam int NH_W  = $clog2(HANDLES + 1);
	localparam int CHD_W = POS_W + 2;

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [HND_W-1:0] hnd_t;
	typedef logic [NH_W-1:0]  nh_t;

	typedef logic [2:0] func_t;
	localparam func_t F_INSERT  = 3'd0;
	localparam func_t F_PEEK    = 3'd1;
	localparam func_t F_DEL_MIN = 3'd2;
	localparam func_t F_DEL_HND = 3'd3;
	localparam func_t F_CHG_HND = 3'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_DEAD  = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_INS,
		OP_DEL0,
		OP_DELH,
		OP_CHG,
		OP_DEL_LD,
		OP_DN_L,
		OP_DN_R,
		OP_DN_C,
		OP_PUT,
		OP_RD_P0,
		OP_UP_LD,
		OP_UP_RD,
		OP_UP_C,
		OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		stat_t  status;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  empty;
		logic  full;
		logic  dead;
		logic  pos_bad;
		logic  del_tail;
		logic  l_ok;
		logic  dn_move;
		logic  up_ok;
		logic  up_move;
	} dp_stat_t;

endpackage

### hw/rtl/imh_dp.sv
module imh_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  imh_pkg::dp_cmd_t  cmd,
	output imh_pkg::dp_stat_t st,
	input  imh_pkg::func_t    func,
	input  imh_pkg::key_t     key,
	input  imh_pkg::hnd_t     handle,
	output imh_pkg::key_t     min_key,
	output imh_pkg::hnd_t     new_handle,
	output imh_pkg::cnt_t     count,
	output logic [1:0]        status,
	output logic              done
);

	// heap storage
	imh_pkg::key_t key_mem [imh_pkg::CAPACITY];
	imh_pkg::hnd_t p2h_mem [imh_pkg::CAPACITY];
	imh_pkg::pos_t h2p_mem [imh_pkg::HANDLES];
	logic          live_mem [imh_pkg::HANDLES];

	imh_pkg::key_t key_rd;
	imh_pkg::hnd_t ph_rd;
	imh_pkg::pos_t h2p_rd;
	logic          live_rd;

	imh_pkg::func_t func_q;
	imh_pkg::key_t  key_q;
	imh_pkg::hnd_t  hnd_q;
	imh_pkg::cnt_t  cnt_q;
	imh_pkg::nh_t   next_q;
	imh_pkg::pos_t  p_q, p0_q, best_pos_q;
	imh_pkg::key_t  cur_key_q, best_key_q;
	imh_pkg::hnd_t  cur_h_q, best_h_q, given_q;
	imh_pkg::key_t  min_key_q;
	imh_pkg::cnt_t  count_q;
	logic [1:0]     status_q;
	logic           done_q;

	imh_pkg::pos_t  rpos, wpos;
	imh_pkg::hnd_t  rhnd, wh, live_wa;
	imh_pkg::key_t  wkey;
	logic           we, live_we, live_wd;

	logic [imh_pkg::CHD_W-1:0] l_pos, r_pos, cnt_x;
	imh_pkg::pos_t  last_pos, par_pos, p_m1;
	logic           r_ok, take_r;
	imh_pkg::key_t  child_key;
	imh_pkg::hnd_t  child_h;
	imh_pkg::pos_t  child_pos;

	assign cnt_x    = imh_pkg::CHD_W'(cnt_q);
	assign l_pos    = {1'b0, p_q, 1'b1};
	assign r_pos    = l_pos + imh_pkg::CHD_W'(1);
	assign r_ok     = r_pos < cnt_x;
	assign last_pos = imh_pkg::POS_W'(cnt_q - imh_pkg::CNT_W'(1));
	assign p_m1     = p_q - imh_pkg::POS_W'(1);
	assign par_pos  = p_m1 >> 1;

	// smaller child, left wins ties
	assign take_r    = r_ok && (key_rd < best_key_q);
	assign child_key = take_r ? key_rd : best_key_q;
	assign child_h   = take_r ? ph_rd : best_h_q;
	assign child_pos = take_r ? r_pos[imh_pkg::POS_W-1:0] : best_pos_q;

	always_comb begin
		st.func     = func_q;
		st.empty    = cnt_q == '0;
		st.full     = (cnt_q == imh_pkg::CNT_W'(imh_pkg::CAPACITY)) ||
			(next_q == imh_pkg::NH_W'(imh_pkg::HANDLES));
		st.dead     = (imh_pkg::NH_W'(hnd_q) >= next_q) || !live_rd;
		st.pos_bad  = imh_pkg::CNT_W'(h2p_rd) >= cnt_q;
		st.del_tail = imh_pkg::CNT_W'(p_q) >= (cnt_q - imh_pkg::CNT_W'(1));
		st.l_ok     = l_pos < cnt_x;
		st.dn_move  = child_key < cur_key_q;
		st.up_ok    = (p_q != '0) && (imh_pkg::CNT_W'(p_q) < cnt_q);
		st.up_move  = cur_key_q < key_rd;
	end

	// read and write port selection
	always_comb begin
		rpos    = '0;
		rhnd    = hnd_q;
		we      = 1'b0;
		wpos    = p_q;
		wkey    = cur_key_q;
		wh      = cur_h_q;
		live_we = 1'b0;
		live_wa = hnd_q;
		live_wd = 1'b0;
		case (cmd.op)
			imh_pkg::OP_ACCEPT: begin
				rhnd = handle;
			end
			imh_pkg::OP_INS: begin
				live_we = 1'b1;
				live_wa = next_q[imh_pkg::HND_W-1:0];
				live_wd = 1'b1;
			end
			imh_pkg::OP_DEL0: begin
				rpos    = last_pos;
				live_we = 1'b1;
				live_wa = ph_rd;
			end
			imh_pkg::OP_DELH: begin
				rpos    = last_pos;
				live_we = 1'b1;
			end
			imh_pkg::OP_DN_L: rpos = l_pos[imh_pkg::POS_W-1:0];
			imh_pkg::OP_DN_R: rpos = r_pos[imh_pkg::POS_W-1:0];
			imh_pkg::OP_DN_C: begin
				we   = st.dn_move;
				wkey = child_key;
				wh   = child_h;
			end
			imh_pkg::OP_PUT:   we = 1'b1;
			imh_pkg::OP_RD_P0: rpos = p0_q;
			imh_pkg::OP_UP_RD: rpos = par_pos;
			imh_pkg::OP_UP_C: begin
				we   = st.up_move;
				wkey = key_rd;
				wh   = ph_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[wpos] <= wkey;
			p2h_mem[wpos] <= wh;
			h2p_mem[wh]   <= wpos;
		end
		key_rd <= key_mem[rpos];
		ph_rd  <= p2h_mem[rpos];
		h2p_rd <= h2p_mem[rhnd];
	end

	always_ff @(posedge clk) begin
		if (live_we)
			live_mem[live_wa] <= live_wd;
		live_rd <= live_mem[rhnd];
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			imh_pkg::OP_ACCEPT: begin
				func_q  <= func;
				key_q   <= key;
				hnd_q   <= handle;
				given_q <= '0;
			end
			imh_pkg::OP_INS: begin
				p_q       <= imh_pkg::POS_W'(cnt_q);
				cur_key_q <= key_q;
				cur_h_q   <= next_q[imh_pkg::HND_W-1:0];
				given_q   <= next_q[imh_pkg::HND_W-1:0];
			end
			imh_pkg::OP_DEL0: p_q <= '0;
			imh_pkg::OP_DELH: p_q <= h2p_rd;
			imh_pkg::OP_CHG: begin
				p_q       <= h2p_rd;
				p0_q      <= h2p_rd;
				cur_key_q <= key_q;
				cur_h_q   <= hnd_q;
			end
			imh_pkg::OP_DEL_LD: begin
				p0_q      <= p_q;
				cur_key_q <= key_rd;
				cur_h_q   <= ph_rd;
			end
			imh_pkg::OP_DN_R: begin
				best_key_q <= key_rd;
				best_h_q   <= ph_rd;
				best_pos_q <= l_pos[imh_pkg::POS_W-1:0];
			end
			imh_pkg::OP_DN_C: begin
				if (st.dn_move)
					p_q <= child_pos;
			end
			imh_pkg::OP_UP_LD: begin
				p_q       <= p0_q;
				cur_key_q <= key_rd;
				cur_h_q   <= ph_rd;
			end
			imh_pkg::OP_UP_C: begin
				if (st.up_move)
					p_q <= par_pos;
			end
			imh_pkg::OP_FIN: begin
				min_key_q <= (cnt_q == '0) ? '0 : key_rd;
				count_q   <= cnt_q;
				status_q  <= cmd.status;
			end
			default: ;
		endcase
	end

	// control counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			next_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.op == imh_pkg::OP_FIN;
			if (cmd.op == imh_pkg::OP_INS) begin
				cnt_q  <= cnt_q + imh_pkg::CNT_W'(1);
				next_q <= next_q + imh_pkg::NH_W'(1);
			end else if (cmd.op == imh_pkg::OP_DEL_LD) begin
				cnt_q <= cnt_q - imh_pkg::CNT_W'(1);
			end
		end
	end

	assign min_key    = min_key_q;
	assign new_handle = given_q;
	assign count      = count_q;
	assign status     = status_q;
	assign done       = done_q;

endmodule

### hw/rtl/imh_ctrl.sv
module imh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  imh_pkg::dp_stat_t st,
	output imh_pkg::dp_cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_DECODE = 14'b00000000000010,
		S_DEL_LD = 14'b00000000000100,
		S_DN_L   = 14'b00000000001000,
		S_DN_R   = 14'b00000000010000,
		S_DN_C   = 14'b00000000100000,
		S_DN_END = 14'b00000001000000,
		S_UP_P0  = 14'b00000010000000,
		S_UP_LD  = 14'b00000100000000,
		S_UP_RD  = 14'b00001000000000,
		S_UP_C   = 14'b00010000000000,
		S_UP_END = 14'b00100000000000,
		S_MIN_RD = 14'b01000000000000,
		S_FIN    = 14'b10000000000000
	} state_t;

	state_t state_q, state_nx;
	imh_pkg::stat_t stat_q, stat_nx;

	always_comb begin
		state_nx   = state_q;
		stat_nx    = stat_q;
		cmd.op     = imh_pkg::OP_NONE;
		cmd.status = stat_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op   = imh_pkg::OP_ACCEPT;
					stat_nx  = imh_pkg::ST_OK;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nx = S_MIN_RD;
				case (st.func)
					imh_pkg::F_INSERT: begin
						if (st.full) begin
							stat_nx = imh_pkg::ST_FULL;
						end else begin
							cmd.op   = imh_pkg::OP_INS;
							state_nx = S_UP_RD;
						end
					end
					imh_pkg::F_PEEK: begin
						if (st.empty)
							stat_nx = imh_pkg::ST_EMPTY;
					end
					imh_pkg::F_DEL_MIN: begin
						if (st.empty) begin
							stat_nx = imh_pkg::ST_EMPTY;
						end else begin
							cmd.op   = imh_pkg::OP_DEL0;
							state_nx = S_DEL_LD;
						end
					end
					imh_pkg::F_DEL_HND: begin
						if (st.dead || st.pos_bad) begin
							stat_nx = imh_pkg::ST_DEAD;
						end else begin
							cmd.op   = imh_pkg::OP_DELH;
							state_nx = S_DEL_LD;
						end
					end
					imh_pkg::F_CHG_HND: begin
						if (st.dead || st.pos_bad) begin
							stat_nx = imh_pkg::ST_DEAD;
						end else begin
							cmd.op   = imh_pkg::OP_CHG;
							state_nx = S_DN_L;
						end
					end
					default: ;
				endcase
			end
			S_DEL_LD: begin
				cmd.op   = imh_pkg::OP_DEL_LD;
				state_nx = st.del_tail ? S_MIN_RD : S_DN_L;
			end
			S_DN_L: begin
				cmd.op   = imh_pkg::OP_DN_L;
				state_nx = st.l_ok ? S_DN_R : S_DN_END;
			end
			S_DN_R: begin
				cmd.op   = imh_pkg::OP_DN_R;
				state_nx = S_DN_C;
			end
			S_DN_C: begin
				cmd.op   = imh_pkg::OP_DN_C;
				state_nx = st.dn_move ? S_DN_L : S_DN_END;
			end
			S_DN_END: begin
				cmd.op   = imh_pkg::OP_PUT;
				state_nx = S_UP_P0;
			end
			S_UP_P0: begin
				cmd.op   = imh_pkg::OP_RD_P0;
				state_nx = S_UP_LD;
			end
			S_UP_LD: begin
				cmd.op   = imh_pkg::OP_UP_LD;
				state_nx = S_UP_RD;
			end
			S_UP_RD: begin
				cmd.op   = imh_pkg::OP_UP_RD;
				state_nx = st.up_ok ? S_UP_C : S_UP_END;
			end
			S_UP_C: begin
				cmd.op   = imh_pkg::OP_UP_C;
				state_nx = st.up_move ? S_UP_RD : S_UP_END;
			end
			S_UP_END: begin
				cmd.op   = imh_pkg::OP_PUT;
				state_nx = S_MIN_RD;
			end
			S_MIN_RD: begin
				state_nx = S_FIN;
			end
			S_FIN: begin
				cmd.op   = imh_pkg::OP_FIN;
				state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= imh_pkg::ST_OK;
		end else begin
			state_q <= state_nx;
			stat_q  <= stat_nx;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

### hw/rtl/indexed_min_heap_core.sv
// sequence: peek and rejected words go from decode to the root read and finish, then done;
// a sift walks the left read, right read and compare states for each level down and
// the parent read and compare states for each level up
// throughput: one word at a time, next start taken the cycle done is high
// sift loops are bound by the single read port of the key and handle stores
// reset: arst_n clears count, issued handles, controller and strobe; stores stay as is
// the receiver cannot stall: done is high for exactly one cycle per word
module indexed_min_heap_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  imh_pkg::func_t func,
	input  imh_pkg::key_t  key,
	input  imh_pkg::hnd_t  handle,
	output imh_pkg::key_t  min_key,
	output imh_pkg::hnd_t  new_handle,
	output imh_pkg::cnt_t  count,
	output logic [1:0]     status,
	output logic           done
);

	// command from the sequencer, flags back from the datapath
	imh_pkg::dp_cmd_t  cmd;
	imh_pkg::dp_stat_t st;

	// sequencer: decode, sift down and then up where the word needs it, read the root, report
	imh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	// heap arrays, handle maps, live bits, counters and result registers
	imh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.func       (func),
		.key        (key),
		.handle     (handle),
		.min_key    (min_key),
		.new_handle (new_handle),
		.count      (count),
		.status     (status),
		.done       (done)
	);

`ifndef SYNTHESIS
	// a result never shows while a word is still being worked on
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// an accepted word makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word not taken up");

	// an empty report always comes with a zero count and zero minimum
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == imh_pkg::ST_EMPTY) |-> (count == '0 && min_key == '0))
		else $error("empty status with keys held");

	// rejected inserts give no handle
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != imh_pkg::ST_OK) |-> new_handle == '0)
		else $error("handle given on failed word");
`endif

endmodule
